// ----- design/ucs_pkg.sv -----
// ============================================================================
// ucs_pkg
// Shared types and character constants for the URI component splitter.
// ============================================================================
package ucs_pkg;

    // Width of every offset field on the result channel
    localparam int OFF_W = 13;

    // Characters with a meaning in the generic URI syntax
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_QMARK = 8'h3F;  // '?'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

    // One byte of URI text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    // Component offsets of one URI
    typedef struct packed {
        logic             scheme_found;
        logic             scheme_relative;
        logic [OFF_W-1:0] scheme_end;
        logic [OFF_W-1:0] path_start;
        logic [OFF_W-1:0] query_start;
        logic [OFF_W-1:0] fragment_start;
        logic             authority_found;
        logic             too_long;
    } t_out;

    // Class of one byte
    typedef struct packed {
        logic letter;
        logic scheme_ch;
        logic slash;
        logic colon;
        logic qmark;
        logic hash;
    } t_char_class;

endpackage

// ----- design/uri_component_splitter_unit.sv -----
// ============================================================================
// uri_component_splitter_unit
// Splits a byte-serial URI into scheme, authority, path, query and fragment
// offsets, giving one result transaction after the byte flagged last.
// ============================================================================
// The final byte passes the input register, then the result register.
// Throughput: one byte per cycle unless a final byte waits on a held result;
// per-byte updates sit between those registers, so bytes enter back to back.
// The result register lets a new URI stream in while a result waits.
// Reset: synchronous, active low; clears the parse state and both valids.
module uri_component_splitter_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ucs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ucs_pkg::t_out o_out_data
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int OFF_W = ucs_pkg::OFF_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    // Scheme phase codes
    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_SLASH1   = 3'd1;
    localparam logic [2:0] PH_NAME     = 3'd2;
    localparam logic [2:0] PH_VALID    = 3'd3;
    localparam logic [2:0] PH_RELATIVE = 3'd4;
    localparam logic [2:0] PH_NONE     = 3'd5;

    // Slash phase codes
    localparam logic [1:0] SL_IDLE  = 2'd0;
    localparam logic [1:0] SL_WANT1 = 2'd1;
    localparam logic [1:0] SL_WANT2 = 2'd2;
    localparam logic [1:0] SL_AUTH  = 2'd3;

    // Input stage
    logic         r_in_vld;
    ucs_pkg::t_in r_in;
    logic         w_adv;
    logic         w_fire;

    // Parse state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_sph, n_sph;
    logic [POS_W-1:0] r_se, n_se;
    logic [1:0]       r_slp, n_slp;
    logic [POS_W-1:0] r_ps, n_ps;
    logic             r_pf, n_pf;
    logic [POS_W-1:0] r_qp, n_qp;
    logic             r_qf, n_qf;
    logic [POS_W-1:0] r_hp, n_hp;
    logic             r_hf, n_hf;
    logic             r_ovf, n_ovf;

    // Result stage
    logic          r_out_vld;
    ucs_pkg::t_out r_out, n_out;

    ucs_pkg::t_char_class w_cls;

    // Classify the registered byte
    ucs_char_class u_class (
        .i_ch    (r_in.ch),
        .o_class (w_cls)
    );

    // Advance the input stage unless a result would overwrite a waiting one
    assign w_adv      = !r_in.last || !r_out_vld || i_out_ready;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_ready = !r_in_vld || w_adv;

    // Update the parse state with one byte
    always_comb begin
        logic [POS_W-1:0] v_p;
        logic [POS_W:0]   v_p1;
        logic             v_scheme_ok;
        logic             v_relative;
        logic             v_entered;
        logic [POS_W-1:0] v_se;
        logic [POS_W-1:0] v_path;
        logic [POS_W-1:0] v_query;
        logic [POS_W-1:0] v_frag;
        logic             v_has_auth;

        v_p   = r_pos;
        v_p1  = {1'b0, r_pos} + 1'b1;
        n_pos = r_pos;
        n_sph = r_sph;
        n_se  = r_se;
        n_slp = r_slp;
        n_ps  = r_ps;
        n_pf  = r_pf;
        n_qp  = r_qp;
        n_qf  = r_qf;
        n_hp  = r_hp;
        n_hf  = r_hf;
        n_ovf = r_ovf;

        if (r_pos >= MAX_POS) begin
            // Drop bytes past the length limit
            n_ovf = 1'b1;
        end else begin
            // Record first query and fragment marks
            if (!r_qf && (w_cls.qmark || w_cls.hash)) begin
                n_qp = v_p;
                n_qf = 1'b1;
            end
            if (!r_hf && w_cls.hash) begin
                n_hp = v_p;
                n_hf = 1'b1;
            end

            // Track the authority opener and its end
            unique case (r_slp)
                SL_WANT1: n_slp = w_cls.slash ? SL_WANT2 : SL_IDLE;
                SL_WANT2: n_slp = w_cls.slash ? SL_AUTH : SL_IDLE;
                SL_AUTH: begin
                    if (w_cls.slash || w_cls.qmark || w_cls.hash) begin
                        n_ps  = v_p;
                        n_pf  = 1'b1;
                        n_slp = SL_IDLE;
                    end
                end
                default: n_slp = r_slp;
            endcase

            // Track the scheme
            unique case (r_sph)
                PH_START: begin
                    if (w_cls.slash) begin
                        n_sph = PH_SLASH1;
                    end else if (w_cls.letter) begin
                        n_sph = PH_NAME;
                    end else begin
                        n_sph = PH_NONE;
                    end
                end
                PH_SLASH1: begin
                    if (w_cls.slash) begin
                        n_sph = PH_RELATIVE;
                        n_se  = '0;
                        n_slp = SL_AUTH;
                    end else begin
                        n_sph = PH_NONE;
                    end
                end
                PH_NAME: begin
                    if (w_cls.colon) begin
                        n_sph = PH_VALID;
                        n_se  = v_p1[POS_W-1:0];
                        n_slp = SL_WANT1;
                    end else if (!w_cls.scheme_ch) begin
                        n_sph = PH_NONE;
                    end
                end
                default: n_sph = r_sph;
            endcase

            n_pos = v_p1[POS_W-1:0];
        end

        // Form the result from the updated state
        v_relative  = (n_sph == PH_RELATIVE);
        v_scheme_ok = v_relative || (n_sph == PH_VALID);
        v_se        = v_scheme_ok ? n_se : '0;
        v_entered   = n_pf || (n_slp == SL_AUTH);
        if (!v_scheme_ok) begin
            v_path = '0;
        end else if (v_entered) begin
            v_path = n_pf ? n_ps : n_pos;
        end else begin
            v_path = v_se;
        end
        v_query    = n_qf ? n_qp : n_pos;
        v_frag     = n_hf ? n_hp : n_pos;
        v_has_auth = v_scheme_ok && v_entered &&
                     ({1'b0, v_path} > ({1'b0, v_se} + (POS_W+1)'(2)));

        n_out.scheme_found    = v_scheme_ok;
        n_out.scheme_relative = v_relative;
        n_out.scheme_end      = OFF_W'(v_se);
        n_out.path_start      = OFF_W'(v_path);
        n_out.query_start     = OFF_W'(v_query);
        n_out.fragment_start  = OFF_W'(v_frag);
        n_out.authority_found = v_has_auth;
        n_out.too_long        = n_ovf;

        // Clear the state after the final byte
        if (r_in.last) begin
            n_pos = '0;
            n_sph = PH_START;
            n_se  = '0;
            n_slp = SL_IDLE;
            n_ps  = '0;
            n_pf  = 1'b0;
            n_qp  = '0;
            n_qf  = 1'b0;
            n_hp  = '0;
            n_hf  = 1'b0;
            n_ovf = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sph <= PH_START;
            r_se  <= '0;
            r_slp <= SL_IDLE;
            r_ps  <= '0;
            r_pf  <= 1'b0;
            r_qp  <= '0;
            r_qf  <= 1'b0;
            r_hp  <= '0;
            r_hf  <= 1'b0;
            r_ovf <= 1'b0;
        end else if (w_fire) begin
            r_pos <= n_pos;
            r_sph <= n_sph;
            r_se  <= n_se;
            r_slp <= n_slp;
            r_ps  <= n_ps;
            r_pf  <= n_pf;
            r_qp  <= n_qp;
            r_qf  <= n_qf;
            r_hp  <= n_hp;
            r_hf  <= n_hf;
            r_ovf <= n_ovf;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && r_in.last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_fire && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // An authority only exists behind a scheme
    a_auth_needs_scheme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.authority_found || o_out_data.scheme_found))
        else $error("authority reported without scheme");

    // A scheme-relative URI has a scheme end of zero
    a_relative_se: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.scheme_relative) |->
            (o_out_data.scheme_found && (o_out_data.scheme_end == '0)))
        else $error("scheme-relative result with nonzero scheme end");

    // The parse state restarts after the final byte
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last) |=> ((r_pos == '0) && (r_sph == PH_START) && !r_ovf))
        else $error("parse state not cleared after final byte");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !(w_fire && r_in.last))
        else $error("result overwritten while stalled");

endmodule

// ----- design/ucs_char_class.sv -----
// ============================================================================
// ucs_char_class
// Classifies one byte into the character groups the splitter looks at.
// ============================================================================
module ucs_char_class (
    input  logic [7:0]           i_ch,
    output ucs_pkg::t_char_class o_class
);

    logic w_upper;
    logic w_lower;
    logic w_digit;

    // Decode letter and digit ranges
    assign w_upper = (i_ch >= 8'h41) && (i_ch <= 8'h5A);
    assign w_lower = (i_ch >= 8'h61) && (i_ch <= 8'h7A);
    assign w_digit = (i_ch >= 8'h30) && (i_ch <= 8'h39);

    // Build the class vector
    always_comb begin
        o_class.letter    = w_upper || w_lower;
        o_class.scheme_ch = w_upper || w_lower || w_digit ||
                            (i_ch == ucs_pkg::CH_PLUS) ||
                            (i_ch == ucs_pkg::CH_MINUS) ||
                            (i_ch == ucs_pkg::CH_DOT);
        o_class.slash     = (i_ch == ucs_pkg::CH_SLASH);
        o_class.colon     = (i_ch == ucs_pkg::CH_COLON);
        o_class.qmark     = (i_ch == ucs_pkg::CH_QMARK);
        o_class.hash      = (i_ch == ucs_pkg::CH_HASH);
    end

endmodule
